[design/dmps_pkg.sv]
// Package for the disjoint min-pair selector: shared widths, command and
// status structs. No dependencies.
`default_nettype none
package dmps_pkg;
    localparam int IDX_BITS = 6;
    localparam int LIMIT_BITS = 6;
    localparam int MAX_OUT = 32;
    localparam int DEF_MAX_NODES = 64;
    localparam int DEF_HEAP_DEPTH = 2048;
    localparam int DEF_SCORE_BITS = 48;

    typedef struct packed {
        logic load;        // write incoming item at count+1
        logic clear_taken; // clear taken marks
        logic sift_start;  // start sift at start slot
        logic pop_start;   // move last to top, then sift from slot 1
        logic mark;        // mark top pair taken
        logic end_run;     // count back to zero
    } dmps_cmd_t;

    typedef struct packed {
        logic sift_busy;
        logic heap_empty;
        logic top_free;
        logic heap_full;
    } dmps_sts_t;
endpackage
`default_nettype wire

[design/dmps_datapath.sv]
// Datapath: heap memory, count, taken marks and the sift-down engine.
// Depends on dmps_pkg.
`default_nettype none
module dmps_datapath #(
    parameter int MAX_NODES = dmps_pkg::DEF_MAX_NODES,
    parameter int HEAP_DEPTH = dmps_pkg::DEF_HEAP_DEPTH,
    parameter int SCORE_BITS = dmps_pkg::DEF_SCORE_BITS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire dmps_pkg::dmps_cmd_t                cmd,
    input  wire logic [$clog2(HEAP_DEPTH)-1:0]      sift_from,
    input  wire logic [dmps_pkg::IDX_BITS-1:0]      in_row,
    input  wire logic [dmps_pkg::IDX_BITS-1:0]      in_col,
    input  wire logic signed [SCORE_BITS-1:0]       in_score,
    output dmps_pkg::dmps_sts_t                     sts,
    output logic [$clog2(HEAP_DEPTH)-1:0]           count,
    output logic [dmps_pkg::IDX_BITS-1:0]           top_row,
    output logic [dmps_pkg::IDX_BITS-1:0]           top_col,
    output logic signed [SCORE_BITS-1:0]            top_score
);
    import dmps_pkg::*;
    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int EW = 2 * IDX_BITS + SCORE_BITS;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_LDP = 6'b000010, S_CHK = 6'b000100,
        S_RDL  = 6'b001000, S_CMP = 6'b010000, S_WR  = 6'b100000
    } sift_state_t;

    logic [EW-1:0] mem [HEAP_DEPTH];
    logic [EW-1:0] rd_data;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    sift_state_t st_reg, st_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] j_reg, j_next;
    logic [AW-1:0] g_reg, g_next;
    logic [EW-1:0] p_reg, p_next, l_reg, l_next, c_reg, c_next;
    logic [EW-1:0] top_reg, top_next;
    logic [MAX_NODES-1:0] taken_reg, taken_next;
    logic [AW:0]   left_w;
    logic          has_right_reg, has_right_next;

    function automatic logic signed [SCORE_BITS-1:0] sc(input logic [EW-1:0] e);
        sc = e[SCORE_BITS-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    assign left_w = {j_reg, 1'b0};

    // The sifted entry stays in p_reg and is written once, where it settles.
    always_comb
    begin
        st_next = st_reg;
        cnt_next = cnt_reg;
        j_next = j_reg;
        g_next = g_reg;
        p_next = p_reg;
        l_next = l_reg;
        c_next = c_reg;
        top_next = top_reg;
        taken_next = taken_reg;
        has_right_next = has_right_reg;
        rd_addr = j_reg;
        wr_en = 1'b0;
        wr_addr = j_reg;
        wr_data = p_reg;
        if (cmd.load)
        begin
            cnt_next = cnt_reg + AW'(1);
            wr_en = 1'b1;
            wr_addr = cnt_next;
            wr_data = {in_row, in_col, in_score};
        end
        if (cmd.clear_taken)
        begin
            taken_next = '0;
        end
        if (cmd.mark)
        begin
            taken_next[top_reg[SCORE_BITS+IDX_BITS +: NW]] = 1'b1;
            taken_next[top_reg[SCORE_BITS +: NW]] = 1'b1;
        end
        if (cmd.end_run)
        begin
            cnt_next = '0;
        end
        unique case (st_reg)
            S_IDLE:
            begin
                if (cmd.sift_start)
                begin
                    rd_addr = sift_from;
                    j_next = sift_from;
                    st_next = S_LDP;
                end
                else if (cmd.pop_start)
                begin
                    // last slot becomes the entry sifted down from the top
                    rd_addr = cnt_reg;
                    j_next = AW'(1);
                    cnt_next = cnt_reg - AW'(1);
                    st_next = S_LDP;
                end
            end
            S_LDP:
            begin
                p_next = rd_data;
                st_next = S_CHK;
            end
            S_CHK:
            begin
                // no child: settle the entry here
                if (left_w > {1'b0, cnt_reg})
                begin
                    wr_en = 1'b1;
                    wr_addr = j_reg;
                    wr_data = p_reg;
                    if (j_reg == AW'(1))
                    begin
                        top_next = p_reg;
                    end
                    st_next = S_IDLE;
                end
                else
                begin
                    rd_addr = left_w[AW-1:0];
                    has_right_next = left_w < {1'b0, cnt_reg};
                    st_next = S_RDL;
                end
            end
            S_RDL:
            begin
                l_next = rd_data;
                rd_addr = left_w[AW-1:0] + AW'(1);
                st_next = S_CMP;
            end
            S_CMP:
            begin
                if (has_right_reg && (sc(l_reg) > sc(rd_data)))
                begin
                    c_next = rd_data;
                    g_next = left_w[AW-1:0] + AW'(1);
                end
                else
                begin
                    c_next = l_reg;
                    g_next = left_w[AW-1:0];
                end
                st_next = S_WR;
            end
            S_WR:
            begin
                wr_en = 1'b1;
                wr_addr = j_reg;
                if (sc(p_reg) > sc(c_reg))
                begin
                    wr_data = c_reg;
                    if (j_reg == AW'(1))
                    begin
                        top_next = c_reg;
                    end
                    j_next = g_reg;
                    st_next = S_CHK;
                end
                else
                begin
                    wr_data = p_reg;
                    if (j_reg == AW'(1))
                    begin
                        top_next = p_reg;
                    end
                    st_next = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            cnt_reg <= '0;
            taken_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            cnt_reg <= cnt_next;
            taken_reg <= taken_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg <= j_next;
        g_reg <= g_next;
        p_reg <= p_next;
        l_reg <= l_next;
        c_reg <= c_next;
        top_reg <= top_next;
        has_right_reg <= has_right_next;
    end

    assign count = cnt_reg;
    assign top_row = top_reg[SCORE_BITS+IDX_BITS +: IDX_BITS];
    assign top_col = top_reg[SCORE_BITS +: IDX_BITS];
    assign top_score = top_reg[SCORE_BITS-1:0];
    assign sts.sift_busy = (st_reg != S_IDLE);
    assign sts.heap_empty = (cnt_reg == '0);
    assign sts.heap_full = (cnt_reg == AW'(HEAP_DEPTH - 1));
    assign sts.top_free = !taken_reg[top_reg[SCORE_BITS+IDX_BITS +: NW]]
                          && !taken_reg[top_reg[SCORE_BITS +: NW]];
endmodule
`default_nettype wire

[design/dmps_ctrl.sv]
// Controller: sequences load, heap build, pops and pair output.
// Depends on dmps_pkg.
`default_nettype none
module dmps_ctrl #(
    parameter int HEAP_DEPTH = dmps_pkg::DEF_HEAP_DEPTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          in_last,
    input  wire logic [dmps_pkg::LIMIT_BITS-1:0] limit,
    input  wire dmps_pkg::dmps_sts_t           sts,
    input  wire logic [$clog2(HEAP_DEPTH)-1:0] count,
    output dmps_pkg::dmps_cmd_t                cmd,
    output logic [$clog2(HEAP_DEPTH)-1:0]      sift_from,
    output logic                               emit,
    output logic                               push,
    output logic                               emit_last,
    input  wire logic                          out_free
);
    import dmps_pkg::*;
    localparam int AW = $clog2(HEAP_DEPTH);

    typedef enum logic [5:0] {
        C_LOAD  = 6'b000001, C_BUILD = 6'b000010, C_BWAIT = 6'b000100,
        C_SEL   = 6'b001000, C_PWAIT = 6'b010000, C_DONE = 6'b100000
    } ctrl_state_t;

    ctrl_state_t st_reg, st_next;
    logic [AW-1:0] h_reg, h_next;
    logic [5:0]    n_reg, n_next;
    logic [5:0]    lim;

    assign lim = (limit == '0) ? 6'd1 : ((limit > 6'd32) ? 6'd32 : limit);

    always_comb
    begin
        st_next = st_reg;
        h_next = h_reg;
        n_next = n_reg;
        cmd = '0;
        in_ready = 1'b0;
        emit = 1'b0;
        push = 1'b0;
        emit_last = 1'b0;
        sift_from = h_reg;
        unique case (st_reg)
            C_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = !sts.heap_full;
                    if (in_last)
                    begin
                        st_next = C_BUILD;
                        n_next = '0;
                    end
                end
            end
            C_BUILD:
            begin
                cmd.clear_taken = 1'b1;
                h_next = count >> 1;
                st_next = C_BWAIT;
            end
            C_BWAIT:
            begin
                if (!sts.sift_busy)
                begin
                    if (h_reg == '0)
                    begin
                        // one extra pass on slot 1 loads the top register
                        cmd.sift_start = !sts.heap_empty;
                        sift_from = AW'(1);
                        st_next = sts.heap_empty ? C_DONE : C_PWAIT;
                    end
                    else
                    begin
                        cmd.sift_start = 1'b1;
                        h_next = h_reg - AW'(1);
                    end
                end
            end
            C_PWAIT:
            begin
                if (!sts.sift_busy)
                begin
                    st_next = C_SEL;
                end
            end
            C_SEL:
            begin
                // the held pair goes out flagged once no more pairs follow
                if (sts.heap_empty || n_reg == lim)
                begin
                    if (n_reg == '0)
                    begin
                        st_next = C_DONE;
                    end
                    else if (out_free)
                    begin
                        push = 1'b1;
                        emit_last = 1'b1;
                        st_next = C_DONE;
                    end
                end
                else if (sts.top_free)
                begin
                    if (n_reg == '0 || out_free)
                    begin
                        emit = 1'b1;
                        push = (n_reg != '0);
                        cmd.mark = 1'b1;
                        n_next = n_reg + 6'd1;
                        cmd.pop_start = 1'b1;
                        st_next = C_PWAIT;
                    end
                end
                else
                begin
                    cmd.pop_start = 1'b1;
                    st_next = C_PWAIT;
                end
            end
            C_DONE:
            begin
                cmd.end_run = 1'b1;
                st_next = C_LOAD;
            end
            default: st_next = C_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= C_LOAD;
            h_reg <= '0;
            n_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            h_reg <= h_next;
            n_reg <= n_next;
        end
    end
endmodule
`default_nettype wire

[design/disjoint_min_pair_selector_top.sv]
// Top level of the disjoint min-pair selector: config register, output
// register, controller and datapath. Depends on dmps_pkg, dmps_ctrl, dmps_datapath.
`default_nettype none
// Entries load one per cycle into the heap RAM from slot 1; once HEAP_DEPTH-1
// entries are held, further entries are dropped. The entry flagged last_entry
// starts a run: a bottom-up heap build, then repeated pops of the minimum
// score. Each sift-down level goes through left read, right read, compare and
// write back on the heap RAM, in a pop and for each inner slot of the build.
// A selected pair waits in a hold register until the next one is found or the
// run ends, so the final pair can carry last_pair; up to pair_limit (1 to 32)
// pairs come out. No input is taken while a run is in progress.
module disjoint_min_pair_selector_top #(
    parameter int MAX_NODES = dmps_pkg::DEF_MAX_NODES,
    parameter int HEAP_DEPTH = dmps_pkg::DEF_HEAP_DEPTH,
    parameter int SCORE_BITS = dmps_pkg::DEF_SCORE_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [dmps_pkg::LIMIT_BITS-1:0]   cfg_wdata,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [dmps_pkg::IDX_BITS-1:0]     row_index,
    input  wire logic [dmps_pkg::IDX_BITS-1:0]     col_index,
    input  wire logic signed [SCORE_BITS-1:0]      score,
    input  wire logic                              last_entry,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [dmps_pkg::IDX_BITS-1:0]          pair_row,
    output logic [dmps_pkg::IDX_BITS-1:0]          pair_col,
    output logic signed [SCORE_BITS-1:0]           pair_score,
    output logic                                   last_pair
);
    import dmps_pkg::*;
    localparam int AW = $clog2(HEAP_DEPTH);

    logic [LIMIT_BITS-1:0] limit_reg;
    dmps_cmd_t cmd;
    dmps_sts_t sts;
    logic [AW-1:0] count, sift_from;
    logic emit, push, emit_last, out_free;
    logic [IDX_BITS-1:0] top_row, top_col;
    logic signed [SCORE_BITS-1:0] top_score;
    logic [IDX_BITS-1:0] hold_row_reg, hold_col_reg;
    logic signed [SCORE_BITS-1:0] hold_score_reg;
    logic ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_BITS'(1);
            ov_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (push)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // hold the newest pair; advance the previous one to the output
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            hold_row_reg <= top_row;
            hold_col_reg <= top_col;
            hold_score_reg <= top_score;
        end
        if (push)
        begin
            pair_row <= hold_row_reg;
            pair_col <= hold_col_reg;
            pair_score <= hold_score_reg;
            last_pair <= emit_last;
        end
    end

    assign out_free = !ov_reg || out_ready;
    assign out_valid = ov_reg;

    dmps_ctrl #(.HEAP_DEPTH(HEAP_DEPTH)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_last(last_entry), .limit(limit_reg), .sts(sts), .count(count),
        .cmd(cmd), .sift_from(sift_from), .emit(emit), .push(push),
        .emit_last(emit_last), .out_free(out_free)
    );

    dmps_datapath #(
        .MAX_NODES(MAX_NODES), .HEAP_DEPTH(HEAP_DEPTH), .SCORE_BITS(SCORE_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sift_from(sift_from),
        .in_row(row_index), .in_col(col_index), .in_score(score), .sts(sts),
        .count(count), .top_row(top_row), .top_col(top_col), .top_score(top_score)
    );
endmodule
`default_nettype wire
